// ===== rtl/core/tplr_pkg.sv =====
// ----------------------------------------------------------------------------
// tplr_pkg
// Shared types and constants for the two-peak lag ratio estimator.
// ----------------------------------------------------------------------------
package tplr_pkg;

  localparam int unsigned REG_ENABLED        = 0;
  localparam int unsigned REG_FIRST_WINDOW   = 1;
  localparam int unsigned REG_FRAME_LAG      = 2;
  localparam int unsigned REG_SECOND_RANGE   = 3;
  localparam int unsigned REG_VISIBLE_PIXELS = 4;

  localparam logic [31:0] RATIO_ONE = 32'h4000_0000;
  localparam logic [31:0] RATIO_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0] RATIO_SAT = 64'hC000_0000;

  typedef struct packed {
    logic        enabled;
    logic [12:0] first_window;
    logic [11:0] frame_lag;
    logic [12:0] second_range;
    logic [23:0] visible_pixels;
  } cfg_t;

endpackage

// ===== rtl/core/two_peak_lag_ratio_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// two_peak_lag_ratio_estimator_unit
// Peak-lag estimator over streamed autocorrelation vectors.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel, s_axis_tlast marking the last sample
// of a vector. Every input word yields one output word on m_axis carrying
// the echoed sample; on a vector end while enabled it also carries the two
// peak indices, and every AVERAGE_COUNT vectors the averaged ratio.
// Registers are written over the APB port while the block is idle; that is
// a rule for the user, which the block itself does not enforce. A sample
// that is not a vector end passes through the queue and then the output
// register before it is valid on m_axis; such samples can follow at one
// word per cycle while m_axis_tready is high. A vector end scans the store
// through its single read port, first window then second window, and when a
// ratio is due, the one-bit-per-cycle division follows.
// A two-word input queue decouples intake from the core. When
// m_axis_tready is low the output word holds and the core stops; input
// backs up through the queue. Reset clears counters, the distance sum and
// the registers to their defaults; the store needs no clear.
// ----------------------------------------------------------------------------
module two_peak_lag_ratio_estimator_unit #(
  parameter int unsigned VECTOR_LEN    = 4096,
  parameter int unsigned AVERAGE_COUNT = 256,
  parameter int unsigned SAMPLE_BITS   = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [4:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // echo_sample, first_peak, second_peak, ratio
  output logic [((SAMPLE_BITS+56+7)/8)*8-1:0]    m_axis_tdata,
  // peaks_valid, ratio_valid
  output logic [1:0]                             m_axis_tuser
);

  localparam int unsigned OUT_W = ((SAMPLE_BITS + 56 + 7) / 8) * 8;

  tplr_pkg::cfg_t         cfg_q;
  logic                   wr;
  logic                   q_valid, q_pop, q_last;
  logic [SAMPLE_BITS-1:0] q_sample, echo;
  logic                   pv, rv;
  logic [11:0]            p1, p2;
  logic [31:0]            ratio;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled        <= 1'b1;
      cfg_q.first_window   <= 13'd4096;
      cfg_q.frame_lag      <= 12'd0;
      cfg_q.second_range   <= 13'd256;
      cfg_q.visible_pixels <= 24'd1;
    end else if (wr) begin
      unique case (paddr[4:2])
        3'(tplr_pkg::REG_ENABLED):        cfg_q.enabled        <= pwdata[0];
        3'(tplr_pkg::REG_FIRST_WINDOW):   cfg_q.first_window   <= pwdata[12:0];
        3'(tplr_pkg::REG_FRAME_LAG):      cfg_q.frame_lag      <= pwdata[11:0];
        3'(tplr_pkg::REG_SECOND_RANGE):   cfg_q.second_range   <= pwdata[12:0];
        3'(tplr_pkg::REG_VISIBLE_PIXELS): cfg_q.visible_pixels <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      3'(tplr_pkg::REG_ENABLED):        prdata = {31'd0, cfg_q.enabled};
      3'(tplr_pkg::REG_FIRST_WINDOW):   prdata = {19'd0, cfg_q.first_window};
      3'(tplr_pkg::REG_FRAME_LAG):      prdata = {20'd0, cfg_q.frame_lag};
      3'(tplr_pkg::REG_SECOND_RANGE):   prdata = {19'd0, cfg_q.second_range};
      3'(tplr_pkg::REG_VISIBLE_PIXELS): prdata = {8'd0, cfg_q.visible_pixels};
      default:                          prdata = 32'd0;
    endcase
  end

  tplr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last_i   (s_axis_tlast),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_sample_o  (q_sample),
    .q_last_o    (q_last)
  );

  tplr_back #(
    .VECTOR_LEN    (VECTOR_LEN),
    .AVERAGE_COUNT (AVERAGE_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_sample_i  (q_sample),
    .q_last_i    (q_last),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_echo_o  (echo),
    .out_pv_o    (pv),
    .out_p1_o    (p1),
    .out_p2_o    (p2),
    .out_rv_o    (rv),
    .out_ratio_o (ratio)
  );

  assign m_axis_tdata = OUT_W'({ratio, p2, p1, echo});
  assign m_axis_tuser = {rv, pv};

endmodule

// ===== rtl/core/tplr_front.sv =====
// ----------------------------------------------------------------------------
// tplr_front
// Input side: accepts words and queues sample plus vector end flag.
// ----------------------------------------------------------------------------
module tplr_front #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                   in_last_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output logic [SAMPLE_BITS-1:0] q_sample_o,
  output logic                   q_last_o
);

  logic [SAMPLE_BITS:0] slot_q [2];
  logic                 wp_q, wp_d, rp_q, rp_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_sample_o = slot_q[rp_q][SAMPLE_BITS-1:0];
  assign q_last_o   = slot_q[rp_q][SAMPLE_BITS];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = q_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= {in_last_i, in_sample_i};
    end
  end

endmodule

// ===== rtl/core/tplr_div.sv =====
// ----------------------------------------------------------------------------
// tplr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tplr_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W:0]   rem_q, rem_sh, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, qbit;

  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    rem_d  = qbit ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== rtl/core/tplr_back.sv =====
// ----------------------------------------------------------------------------
// tplr_back
// Vector store, two peak scans, distance averaging and output register.
// ----------------------------------------------------------------------------
module tplr_back #(
  parameter int unsigned VECTOR_LEN    = 4096,
  parameter int unsigned AVERAGE_COUNT = 256,
  parameter int unsigned SAMPLE_BITS   = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tplr_pkg::cfg_t         cfg_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic [SAMPLE_BITS-1:0] q_sample_i,
  input  logic                   q_last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] out_echo_o,
  output logic                   out_pv_o,
  output logic [11:0]            out_p1_o,
  output logic [11:0]            out_p2_o,
  output logic                   out_rv_o,
  output logic [31:0]            out_ratio_o
);

  localparam int unsigned IDX_W = $clog2(VECTOR_LEN);
  localparam int unsigned AW    = IDX_W + 1;
  localparam int unsigned EW    = ((IDX_W > 13) ? IDX_W : 13) + 2;
  localparam int unsigned CNT_W = $clog2(AVERAGE_COUNT + 1);
  localparam int unsigned SUM_W = IDX_W + CNT_W;
  localparam int unsigned NUM_W = SUM_W + 31;
  localparam int unsigned DEN_W = 24 + CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [SAMPLE_BITS-1:0] mem [VECTOR_LEN];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [IDX_W-1:0]     pos_q, last_q;
  logic [AW-1:0]        addr_q, end_q, ri_q;
  logic                 rv_q, phase_q, first_q;
  logic [SAMPLE_BITS-1:0] best_q;
  logic [IDX_W-1:0]     best_i_q, p1_q;
  logic [SUM_W-1:0]     sum_q, sum_new;
  logic [CNT_W-1:0]     cnt_q, cnt_new;
  logic [DEN_W-1:0]     den_q;
  logic                 out_free, issue, do_pop, div_start, div_done;
  logic [NUM_W-1:0]     div_num, quo;
  logic [EW-1:0]        len_e, w1, end1, start2, s2c, end2;
  logic [IDX_W-1:0]     best_fin;
  logic [SAMPLE_BITS-1:0] echo_q;
  logic                 pv_q, rv_out_q, ov_q;
  logic [IDX_W-1:0]     o1_q, o2_q;
  logic [31:0]          ratio_q, ratio_c;

  assign out_free = !ov_q || out_ready_i;
  assign do_pop   = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = do_pop;
  assign issue    = (state_q == ST_SCAN) && (addr_q < end_q);

  // final compare of the scan, folded in when the last read lands
  assign best_fin = (rv_q && (first_q || $signed(rd_q) > $signed(best_q)))
                    ? ri_q[IDX_W-1:0] : best_i_q;

  always_comb begin
    len_e   = EW'(last_q) + EW'(1);
    w1      = (cfg_i.first_window == 13'd0) ? EW'(1) : EW'(cfg_i.first_window);
    end1    = (w1 > EW'(pos_q) + EW'(1)) ? EW'(pos_q) + EW'(1) : w1;
    start2  = EW'(best_fin) + EW'(cfg_i.frame_lag);
    s2c     = (start2 > EW'(last_q)) ? EW'(last_q) : start2;
    end2    = s2c + ((cfg_i.second_range == 13'd0) ? EW'(1) : EW'(cfg_i.second_range));
    if (end2 > len_e) begin
      end2 = len_e;
    end
    sum_new = sum_q + SUM_W'(best_fin - p1_q);
    cnt_new = cnt_q + 1'b1;
    div_num = (NUM_W'(sum_new) << 30) + NUM_W'(den_q >> 1);
  end

  assign div_start = (state_q == ST_SCAN) && !issue && !rv_q && phase_q
                     && (cnt_new == CNT_W'(AVERAGE_COUNT));

  always_comb begin
    if (quo >= NUM_W'(tplr_pkg::RATIO_SAT)) begin
      ratio_c = tplr_pkg::RATIO_MAX;
    end else begin
      ratio_c = 32'(quo) - tplr_pkg::RATIO_ONE;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_pop && q_last_i && cfg_i.enabled) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !rv_q && phase_q) state_d = div_start ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      mem[pos_q] <= q_sample_i;
    end
    rd_q <= mem[addr_q[IDX_W-1:0]];
    den_q <= DEN_W'(AVERAGE_COUNT)
             * DEN_W'((cfg_i.visible_pixels == 24'd0) ? 24'd1 : cfg_i.visible_pixels);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (do_pop) begin
        if (q_last_i) begin
          pos_q <= '0;
        end else if (pos_q != IDX_W'(VECTOR_LEN - 1)) begin
          pos_q <= pos_q + 1'b1;
        end
        if (!(q_last_i && cfg_i.enabled)) begin
          ov_q <= 1'b1;
        end
      end
      if ((state_q == ST_SCAN) && !issue && !rv_q && phase_q) begin
        sum_q <= div_start ? '0 : sum_new;
        cnt_q <= div_start ? '0 : cnt_new;
      end
      if ((state_q == ST_OUT) && out_free) begin
        ov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      echo_q   <= q_sample_i;
      last_q   <= pos_q;
      addr_q   <= '0;
      end_q    <= AW'(end1);
      phase_q  <= 1'b0;
      first_q  <= 1'b1;
      pv_q     <= 1'b0;
      rv_out_q <= 1'b0;
      o1_q     <= '0;
      o2_q     <= '0;
      ratio_q  <= '0;
    end
    if (issue) begin
      addr_q <= addr_q + 1'b1;
      ri_q   <= addr_q;
    end
    if (rv_q) begin
      first_q  <= 1'b0;
      best_i_q <= best_fin;
      if (first_q || $signed(rd_q) > $signed(best_q)) begin
        best_q <= rd_q;
      end
    end
    if ((state_q == ST_SCAN) && !issue && !rv_q) begin
      if (!phase_q) begin
        p1_q    <= best_fin;
        addr_q  <= AW'(s2c);
        end_q   <= AW'(end2);
        phase_q <= 1'b1;
        first_q <= 1'b1;
      end else begin
        pv_q <= 1'b1;
        o1_q <= p1_q;
        o2_q <= best_fin;
      end
    end
    if (div_done) begin
      rv_out_q <= 1'b1;
      ratio_q  <= ratio_c;
    end
  end

  tplr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_valid_o = ov_q;
  assign out_echo_o  = echo_q;
  assign out_pv_o    = pv_q;
  assign out_p1_o    = 12'(o1_q);
  assign out_p2_o    = 12'(o2_q);
  assign out_rv_o    = rv_out_q;
  assign out_ratio_o = ratio_q;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_peak_lag_ratio_estimator_unit: streams
// autocorrelation vectors under several register settings, predicts each
// output word and compares it field by field in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned VLEN  = 4096;
  localparam int unsigned AVG_N = 256;

  typedef struct {
    logic [23:0] echo;
    logic        pv;
    logic [11:0] p1;
    logic [11:0] p2;
    logic        rv;
    logic [31:0] ratio;
  } word_t;

  class peak_scoreboard;
    logic signed [23:0] mem [VLEN];
    int unsigned pos;
    longint unsigned dsum;
    int unsigned vcnt;
    tplr_pkg::cfg_t cfg;
    word_t due [$];
    int fails;

    function new();
      pos = 0; dsum = 0; vcnt = 0; fails = 0;
      cfg.enabled = 1'b1; cfg.first_window = 13'd4096; cfg.frame_lag = '0;
      cfg.second_range = 13'd256; cfg.visible_pixels = 24'd1;
    endfunction

    function void set_reg(int unsigned idx, logic [31:0] v);
      case (idx)
        tplr_pkg::REG_ENABLED:        cfg.enabled = v[0];
        tplr_pkg::REG_FIRST_WINDOW:   cfg.first_window = v[12:0];
        tplr_pkg::REG_FRAME_LAG:      cfg.frame_lag = v[11:0];
        tplr_pkg::REG_SECOND_RANGE:   cfg.second_range = v[12:0];
        tplr_pkg::REG_VISIBLE_PIXELS: cfg.visible_pixels = v[23:0];
        default: ;
      endcase
    endfunction

    function int unsigned peak_at(int unsigned st, int unsigned e);
      int unsigned best;
      best = st;
      for (int unsigned i = st + 1; i < e; i++)
        if (mem[i] > mem[best]) best = i;
      return best;
    endfunction

    function void note(logic [23:0] smp, logic last);
      word_t w;
      int unsigned len, w1, a, b, st, r2, e;
      longint unsigned dd, q;
      longint r;
      w = '{smp, 1'b0, 12'd0, 12'd0, 1'b0, 32'd0};
      mem[pos] = smp;
      if (last) begin
        if (cfg.enabled) begin
          len = pos + 1;
          w1 = (cfg.first_window == 0) ? 1 : cfg.first_window;
          if (w1 > len) w1 = len;
          a = peak_at(0, w1);
          st = a + cfg.frame_lag;
          if (st > len - 1) st = len - 1;
          r2 = (cfg.second_range == 0) ? 1 : cfg.second_range;
          e = st + r2;
          if (e > len) e = len;
          b = peak_at(st, e);
          w.pv = 1'b1; w.p1 = a[11:0]; w.p2 = b[11:0];
          dsum += b - a;
          vcnt++;
          if (vcnt >= AVG_N) begin
            dd = AVG_N * ((cfg.visible_pixels == 0) ? 64'd1 : 64'(cfg.visible_pixels));
            q = ((dsum << 30) + dd / 2) / dd;
            r = longint'(q) - (longint'(1) << 30);
            if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
            w.rv = 1'b1; w.ratio = r[31:0];
            dsum = 0; vcnt = 0;
          end
        end
        pos = 0;
      end else if (pos < VLEN - 1) begin
        pos++;
      end
      due.push_back(w);
    endfunction

    function void check(logic [79:0] d, logic [1:0] u);
      word_t w;
      if (due.size() == 0) begin
        $display("%0t: unexpected word, actual data %h user %b", $time, d, u);
        fails++;
        return;
      end
      w = due.pop_front();
      if (d[23:0] !== w.echo) begin
        $display("%0t: echo exp %h act %h", $time, w.echo, d[23:0]); fails++;
      end
      if (u[0] !== w.pv) begin
        $display("%0t: peaks_valid exp %b act %b", $time, w.pv, u[0]); fails++;
      end
      if (d[35:24] !== w.p1) begin
        $display("%0t: first_peak exp %0d act %0d", $time, w.p1, d[35:24]); fails++;
      end
      if (d[47:36] !== w.p2) begin
        $display("%0t: second_peak exp %0d act %0d", $time, w.p2, d[47:36]); fails++;
      end
      if (u[1] !== w.rv) begin
        $display("%0t: ratio_valid exp %b act %b", $time, w.rv, u[1]); fails++;
      end
      if (d[79:48] !== w.ratio) begin
        $display("%0t: ratio exp %h act %h", $time, w.ratio, d[79:48]); fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // sample
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // echo_sample, first_peak, second_peak, ratio
  logic [1:0]  m_axis_tuser;       // peaks_valid, ratio_valid

  peak_scoreboard sb = new();
  int burst_left = 0;
  bit hold_req = 1'b0;

  two_peak_lag_ratio_estimator_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note(s_axis_tdata, s_axis_tlast);
    if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  // receiver stall pattern with one long hold-off on request
  int rx_cnt = 0, rx_mode = 0, hold_left = 0;
  always @(posedge clk_i) begin
    rx_cnt++;
    if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic reg_write(int unsigned idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send(logic [23:0] smp, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (sb.due.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic setup(logic en, int unsigned fw, int unsigned lag, int unsigned sr,
                       int unsigned vp);
    drain();
    reg_write(tplr_pkg::REG_ENABLED, 32'(en));
    reg_write(tplr_pkg::REG_FIRST_WINDOW, 32'(fw));
    reg_write(tplr_pkg::REG_FRAME_LAG, 32'(lag));
    reg_write(tplr_pkg::REG_SECOND_RANGE, 32'(sr));
    reg_write(tplr_pkg::REG_VISIBLE_PIXELS, 32'(vp));
  endtask

  function automatic logic [23:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 3));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_vectors(int unsigned n_items, int unsigned max_len);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send(rnd_sample(), $urandom_range(0, 1));
        else send(rnd_sample(), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic run_phase(int unsigned n_items, int unsigned max_len);
    int unsigned fw, lag, sr;
    fw = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 8191);
    lag = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 4095);
    sr = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 8191);
    setup($urandom_range(0, 7) != 0, fw, lag, sr,
          $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 24'hFFFFFF));
    random_vectors(n_items, max_len);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, ties (earliest wins), single-sample vectors
    setup(1'b1, 4096, 0, 256, 1);
    send(24'h7FFFFF, 1'b1);
    send(24'h800000, 1'b1);
    send(24'h000005, 1'b0); send(24'h000009, 1'b0); send(24'h000009, 1'b0);
    send(24'h800000, 1'b1);
    setup(1'b1, 0, 4095, 0, 0);
    send(24'h000001, 1'b0); send(24'h7FFFFF, 1'b0); send(24'h000002, 1'b1);
    send(24'h7FFFFF, 1'b1);
    setup(1'b1, 2, 1, 2, 24'hFFFFFF);
    send(24'hFFFFFF, 1'b0); send(24'h000000, 1'b0); send(24'h000003, 1'b0);
    send(24'h000003, 1'b0); send(24'h000001, 1'b1);
    setup(1'b0, 1, 0, 1, 1);
    send(24'h123456, 1'b0); send(24'h654321, 1'b1);
    setup(1'b1, 8191, 3, 8191, 7);
    send(24'h000010, 1'b0); send(24'h7FFFFF, 1'b0); send(24'h7FFFFF, 1'b0);
    send(24'h000000, 1'b0); send(24'h000000, 1'b1);

    // large distances push the ratio into saturation, one long hold-off
    setup(1'b1, 1, 4, 4096, 1);
    hold_req = 1'b1;
    for (int v = 0; v < 250; v++)
      for (int i = 0; i < 5; i++) send(rnd_sample(), i == 4);

    // random phases with several settings
    setup(1'b1, 4096, 0, 4096, 1);
    random_vectors(60, 3);
    repeat (2) run_phase(30, 3);

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tplr_pkg.sv
rtl/core/tplr_front.sv
rtl/core/tplr_div.sv
rtl/core/tplr_back.sv
rtl/core/two_peak_lag_ratio_estimator_unit.sv
test/tb.sv
